// ----- hw/rtl/credential_key_store_core_assert.svh -----
// Assertion macros for the credential key store core.
// Each macro expects clk and arst_n in scope; the checks are off while reset is low.
`ifndef CREDENTIAL_KEY_STORE_CORE_ASSERT_SVH
`define CREDENTIAL_KEY_STORE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CKS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cks_pkg.sv -----
// Shared types and constants for the credential key store.
// No dependencies.
`timescale 1ns / 1ps

package cks_pkg;

	// Store capacity and derived widths.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	// Operation codes.
	localparam logic [1:0] FUNC_STORE  = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_LIST   = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	// One stored credential: 160-bit hash, 128-bit id, 168-bit key.
	typedef struct packed {
		logic [63:0] hash_hi;
		logic [63:0] hash_mid;
		logic [31:0] hash_lo;
		logic [63:0] cred_hi;
		logic [63:0] cred_lo;
		logic [63:0] priv_hi;
		logic [63:0] priv_mid;
		logic [39:0] priv_lo;
	} entry_t;

endpackage

// ----- hw/rtl/credential_key_store_core.sv -----
// Credential key store core: entry memory, count and a scan sequencer around one hash comparator.
// Store, clear and list header results appear the cycle after accept; lookup reads and compares entries in turn.
// List: each entry passes read, compare/format and output slot after the previous result is taken.
// One transaction at a time; the next request is taken the cycle after the final result leaves.
// Reset (arst_n low, async) empties the store; entry contents are not cleared.
// Depends on cks_pkg and credential_key_store_core_assert.svh.
`timescale 1ns / 1ps

module credential_key_store_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [63:0] hash_hi,
	input  logic [63:0] hash_mid,
	input  logic [31:0] hash_lo,
	input  logic [63:0] cred_hi,
	input  logic [63:0] cred_lo,
	input  logic [63:0] priv_hi,
	input  logic [63:0] priv_mid,
	input  logic [39:0] priv_lo,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [4:0]  entry_total,
	output logic [63:0] out_hash_hi,
	output logic [63:0] out_hash_mid,
	output logic [31:0] out_hash_lo,
	output logic [63:0] out_cred_hi,
	output logic [63:0] out_cred_lo,
	output logic [63:0] out_priv_hi,
	output logic [63:0] out_priv_mid,
	output logic [39:0] out_priv_lo,
	output logic        last
);

	`include "credential_key_store_core_assert.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EVAL,
		S_OUT
	} state_t;

	state_t state_q;

	logic [cks_pkg::CNT_W-1:0] count_q;
	logic [cks_pkg::IDX_W-1:0] idx_q;
	logic                      list_q;   // current transaction is a list
	logic                      hdr_q;    // list header is in the output slot
	logic                      more_q;   // list entries still to send

	// request hash kept for the scan
	logic [63:0] req_hash_hi_q;
	logic [63:0] req_hash_mid_q;
	logic [31:0] req_hash_lo_q;

	// output slot
	logic [1:0]  status_q;
	logic [4:0]  total_q;
	logic [63:0] o_hash_hi_q;
	logic [63:0] o_hash_mid_q;
	logic [31:0] o_hash_lo_q;
	logic [63:0] o_cred_hi_q;
	logic [63:0] o_cred_lo_q;
	logic [63:0] o_priv_hi_q;
	logic [63:0] o_priv_mid_q;
	logic [39:0] o_priv_lo_q;
	logic        last_q;

	// entry memory
	cks_pkg::entry_t mem [cks_pkg::MAX_ENTRIES];
	cks_pkg::entry_t rd_q;
	cks_pkg::entry_t wr_entry;

	logic accept;
	logic store_ok;
	logic hit;
	logic at_end;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign store_ok  = (func == cks_pkg::FUNC_STORE) && (count_q < cks_pkg::MAX_CNT);

	// shared comparator: read entry hash against request hash
	assign hit = (rd_q.hash_hi == req_hash_hi_q) && (rd_q.hash_mid == req_hash_mid_q)
		&& (rd_q.hash_lo == req_hash_lo_q);
	assign at_end = (cks_pkg::CNT_W'(idx_q) == (count_q - cks_pkg::CNT_W'(1)));

	assign wr_entry = '{
		hash_hi:  hash_hi,
		hash_mid: hash_mid,
		hash_lo:  hash_lo,
		cred_hi:  cred_hi,
		cred_lo:  cred_lo,
		priv_hi:  priv_hi,
		priv_mid: priv_mid,
		priv_lo:  priv_lo
	};

	// memory: write at the count on a store, registered read at the scan index
	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			mem[count_q[cks_pkg::IDX_W-1:0]] <= wr_entry;
		end
		rd_q <= mem[idx_q];
	end

	// sequencer and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			idx_q          <= '0;
			list_q         <= 1'b0;
			hdr_q          <= 1'b0;
			more_q         <= 1'b0;
			req_hash_hi_q  <= '0;
			req_hash_mid_q <= '0;
			req_hash_lo_q  <= '0;
			status_q       <= cks_pkg::STAT_OK;
			total_q        <= '0;
			o_hash_hi_q    <= '0;
			o_hash_mid_q   <= '0;
			o_hash_lo_q    <= '0;
			o_cred_hi_q    <= '0;
			o_cred_lo_q    <= '0;
			o_priv_hi_q    <= '0;
			o_priv_mid_q   <= '0;
			o_priv_lo_q    <= '0;
			last_q         <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_hash_hi_q  <= hash_hi;
						req_hash_mid_q <= hash_mid;
						req_hash_lo_q  <= hash_lo;
						idx_q          <= '0;
						list_q         <= (func == cks_pkg::FUNC_LIST);
						hdr_q          <= (func == cks_pkg::FUNC_LIST);
						more_q         <= 1'b0;
						status_q       <= cks_pkg::STAT_OK;
						total_q        <= '0;
						o_hash_hi_q    <= '0;
						o_hash_mid_q   <= '0;
						o_hash_lo_q    <= '0;
						o_cred_hi_q    <= '0;
						o_cred_lo_q    <= '0;
						o_priv_hi_q    <= '0;
						o_priv_mid_q   <= '0;
						o_priv_lo_q    <= '0;
						last_q         <= 1'b1;
						state_q        <= S_OUT;
						unique case (func)
							cks_pkg::FUNC_STORE: begin
								if (store_ok) begin
									count_q <= count_q + cks_pkg::CNT_W'(1);
								end else begin
									status_q <= cks_pkg::STAT_FULL;
								end
							end
							cks_pkg::FUNC_LOOKUP: begin
								if (count_q == '0) begin
									status_q <= cks_pkg::STAT_NOT_FOUND;
								end else begin
									state_q <= S_RD;
								end
							end
							cks_pkg::FUNC_LIST: begin
								total_q <= 5'(count_q);
								last_q  <= (count_q == '0);
								more_q  <= (count_q != '0);
							end
							cks_pkg::FUNC_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (list_q) begin
						// list entry: hash and id
						status_q     <= cks_pkg::STAT_OK;
						total_q      <= '0;
						o_hash_hi_q  <= rd_q.hash_hi;
						o_hash_mid_q <= rd_q.hash_mid;
						o_hash_lo_q  <= rd_q.hash_lo;
						o_cred_hi_q  <= rd_q.cred_hi;
						o_cred_lo_q  <= rd_q.cred_lo;
						last_q       <= at_end;
						more_q       <= !at_end;
						state_q      <= S_OUT;
					end else if (hit) begin
						// lookup hit: id and key
						status_q     <= cks_pkg::STAT_OK;
						o_cred_hi_q  <= rd_q.cred_hi;
						o_cred_lo_q  <= rd_q.cred_lo;
						o_priv_hi_q  <= rd_q.priv_hi;
						o_priv_mid_q <= rd_q.priv_mid;
						o_priv_lo_q  <= rd_q.priv_lo;
						last_q       <= 1'b1;
						state_q      <= S_OUT;
					end else if (at_end) begin
						status_q <= cks_pkg::STAT_NOT_FOUND;
						last_q   <= 1'b1;
						state_q  <= S_OUT;
					end else begin
						idx_q   <= idx_q + cks_pkg::IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (!rsp_stall) begin
						hdr_q <= 1'b0;
						if (more_q) begin
							// header leaves index 0; an entry moves to the next one
							if (!hdr_q) begin
								idx_q <= idx_q + cks_pkg::IDX_W'(1);
							end
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = (state_q == S_OUT);
	assign status       = status_q;
	assign entry_total  = total_q;
	assign out_hash_hi  = o_hash_hi_q;
	assign out_hash_mid = o_hash_mid_q;
	assign out_hash_lo  = o_hash_lo_q;
	assign out_cred_hi  = o_cred_hi_q;
	assign out_cred_lo  = o_cred_lo_q;
	assign out_priv_hi  = o_priv_hi_q;
	assign out_priv_mid = o_priv_mid_q;
	assign out_priv_lo  = o_priv_lo_q;
	assign last         = last_q;

	// checks
	`CKS_ASSERT_NOW(a_count_range, 1'b1, count_q <= cks_pkg::MAX_CNT, "entry count above capacity")
	`CKS_ASSERT_NOW(a_busy_while_out, rsp_valid, req_stall, "request taken while a result waits")
	`CKS_ASSERT_NEXT(a_store_grows, accept && store_ok, count_q == $past(count_q) + cks_pkg::CNT_W'(1), "store did not grow the count")
	`CKS_ASSERT_NOW(a_scan_in_range, state_q == S_RD, cks_pkg::CNT_W'(idx_q) < count_q, "scan index beyond stored entries")
	`CKS_ASSERT_NOW(a_more_not_last, rsp_valid && more_q, !last_q, "last set while list entries remain")

endmodule
